/* hw/rtl/mseu_pkg.sv */
// Shared types and constants of the MIPS subset execute unit.
`default_nettype none

package mseu_pkg;

  // Fixed sizes
  localparam int unsigned REG_COUNT  = 32;
  localparam int unsigned REG_IDX_W  = 5;
  localparam int unsigned ACC_ADDR_W = 14;

  // Item modes
  localparam logic [1:0] MODE_EXEC  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_DONE      = 3'd0;
  localparam logic [2:0] ST_BAD_FUNCT = 3'd1;
  localparam logic [2:0] ST_ILLEGAL   = 3'd2;
  localparam logic [2:0] ST_END       = 3'd3;
  localparam logic [2:0] ST_HALTED    = 3'd4;

  // Opcodes and R-type function
  localparam logic [5:0] OP_RTYPE  = 6'h00;
  localparam logic [5:0] OP_J      = 6'h02;
  localparam logic [5:0] OP_BGE    = 6'h07;
  localparam logic [5:0] OP_ADDI   = 6'h08;
  localparam logic [5:0] OP_LB     = 6'h20;
  localparam logic [5:0] OP_LW     = 6'h23;
  localparam logic [5:0] OP_SW     = 6'h2B;
  localparam logic [5:0] OP_LA     = 6'h2F;
  localparam logic [5:0] FUNCT_ADD = 6'h20;

  // Data memory request, byte address before wrap
  typedef struct packed {
    logic        rd_en;
    logic        wr_en;
    logic        byte_op;
    logic [31:0] addr;
    logic [31:0] wdata;
  } mem_req_t;

  // Register writeback; load takes its data from memory later
  typedef struct packed {
    logic                 en;
    logic                 load;
    logic [REG_IDX_W-1:0] dest;
    logic [31:0]          data;
  } reg_wb_t;

  // Everything the execute stage decides for one word
  typedef struct packed {
    logic [31:0] pc_next;
    logic [2:0]  status;
    logic        set_halt;
    mem_req_t    mem;
    reg_wb_t     wb;
  } exec_res_t;

endpackage

`default_nettype wire

/* hw/rtl/mseu_regfile.sv */
// Register file: 32 x 32 synchronous memory, two read ports, one write port.
`default_nettype none

module mseu_regfile (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           rd_en_i,
  input  logic [mseu_pkg::REG_IDX_W-1:0] rs_addr_i,
  input  logic [mseu_pkg::REG_IDX_W-1:0] rt_addr_i,
  input  logic                           we_i,
  input  logic [mseu_pkg::REG_IDX_W-1:0] waddr_i,
  input  logic [31:0]                    wdata_i,
  output logic [31:0]                    rs_data_o,
  output logic [31:0]                    rt_data_o
);

  logic [31:0]                     mem [mseu_pkg::REG_COUNT];
  logic [mseu_pkg::REG_COUNT-1:0]  vld_q;
  logic [31:0]                     rs_q;
  logic [31:0]                     rt_q;
  logic                            rs_ok_q;
  logic                            rt_ok_q;

  // Storage and registered read data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (rd_en_i) begin
      rs_q <= mem[rs_addr_i];
      rt_q <= mem[rt_addr_i];
    end
  end

  // Written flags: an entry never written reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      rs_ok_q <= 1'b0;
      rt_ok_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rs_ok_q <= vld_q[rs_addr_i];
        rt_ok_q <= vld_q[rt_addr_i];
      end
    end
  end

  assign rs_data_o = rs_ok_q ? rs_q : '0;
  assign rt_data_o = rt_ok_q ? rt_q : '0;

endmodule

`default_nettype wire

/* hw/rtl/mseu_dmem.sv */
// Data memory: four byte banks, little-endian, unaligned word access with wrap.
`default_nettype none

module mseu_dmem #(
  parameter int unsigned MEM_BYTES = 16384
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  mseu_pkg::mem_req_t req_i,
  output logic [31:0]        rd_word_o
);

  localparam int unsigned ADDR_W = $clog2(MEM_BYTES);
  localparam int unsigned ROW_W  = ADDR_W - 2;
  localparam int unsigned ROWS   = MEM_BYTES / 4;

  logic [ADDR_W-1:0] addr;
  logic [1:0]        off;
  logic [ROW_W-1:0]  row;
  logic [ROW_W-1:0]  row_nx;
  logic [31:0]       wrot;
  logic [31:0]       rd_bytes;
  logic [1:0]        off_q;

  // Byte address wraps at the memory size; a word may spill into the next row
  assign addr   = req_i.addr[ADDR_W-1:0];
  assign off    = addr[1:0];
  assign row    = addr[ADDR_W-1:2];
  assign row_nx = row + 1'b1;

  // Byte k of the word lands in bank (off + k) mod 4
  assign wrot = (req_i.wdata << {off, 3'b000}) | (req_i.wdata >> (6'd32 - {1'b0, off, 3'b000}));

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [7:0]       bank_mem [ROWS];
    logic [7:0]       rd_q;
    logic [ROW_W-1:0] bank_row;

    assign bank_row = (2'(b) >= off) ? row : row_nx;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (req_i.wr_en) begin
          bank_mem[bank_row] <= wrot[8*b +: 8];
        end
        if (req_i.rd_en) begin
          rd_q <= bank_mem[bank_row];
        end
      end
    end

    assign rd_bytes[8*b +: 8] = rd_q;
  end

  // Offset of the pending read, for realignment
  always_ff @(posedge clk_i) begin
    if (en_i && req_i.rd_en) begin
      off_q <= off;
    end
  end

  assign rd_word_o = (rd_bytes >> {off_q, 3'b000}) | (rd_bytes << (6'd32 - {1'b0, off_q, 3'b000}));

endmodule

`default_nettype wire

/* hw/rtl/mseu_exec.sv */
// Execute stage: decode, ALU, branch and jump targets, memory request.
`default_nettype none

module mseu_exec (
  input  logic [1:0]                        mode_i,
  input  logic [31:0]                       instruction_i,
  input  logic [mseu_pkg::ACC_ADDR_W-1:0]   access_address_i,
  input  logic [31:0]                       access_data_i,
  input  logic [31:0]                       pc_i,
  input  logic                              halted_i,
  input  logic [31:0]                       rs_data_i,
  input  logic [31:0]                       rt_data_i,
  output mseu_pkg::exec_res_t               res_o
);

  logic [5:0]  op;
  logic [5:0]  funct;
  logic [4:0]  rt_idx;
  logic [4:0]  rd_idx;
  logic [31:0] imm_s;
  logic [31:0] imm_z;
  logic [31:0] seq;
  logic [31:0] ea;
  logic [31:0] sum;
  logic        wb_en;

  // Instruction fields
  assign op     = instruction_i[31:26];
  assign funct  = instruction_i[5:0];
  assign rt_idx = instruction_i[20:16];
  assign rd_idx = instruction_i[15:11];
  assign imm_s  = {{16{instruction_i[15]}}, instruction_i[15:0]};
  assign imm_z  = {16'h0000, instruction_i[15:0]};
  assign seq    = pc_i + 32'd4;
  assign ea     = rs_data_i + imm_s;
  assign sum    = rs_data_i + rt_data_i;

  always_comb begin
    res_o         = '0;
    res_o.pc_next = pc_i;
    res_o.status  = mseu_pkg::ST_DONE;
    wb_en         = 1'b0;

    unique case (mode_i)
      mseu_pkg::MODE_EXEC: begin
        if (halted_i) begin
          res_o.status = mseu_pkg::ST_HALTED;
        end else if (instruction_i == '0) begin
          res_o.status   = mseu_pkg::ST_END;
          res_o.set_halt = 1'b1;
        end else begin
          res_o.pc_next = seq;
          unique case (op)
            mseu_pkg::OP_LA: begin
              wb_en          = 1'b1;
              res_o.wb.dest  = rt_idx;
              res_o.wb.data  = imm_z;
            end
            mseu_pkg::OP_LB, mseu_pkg::OP_LW: begin
              wb_en             = 1'b1;
              res_o.wb.dest     = rt_idx;
              res_o.wb.load     = 1'b1;
              res_o.mem.rd_en   = 1'b1;
              res_o.mem.byte_op = (op == mseu_pkg::OP_LB);
              res_o.mem.addr    = ea;
            end
            mseu_pkg::OP_SW: begin
              res_o.mem.wr_en = 1'b1;
              res_o.mem.addr  = ea;
              res_o.mem.wdata = rt_data_i;
            end
            mseu_pkg::OP_ADDI: begin
              wb_en         = 1'b1;
              res_o.wb.dest = rt_idx;
              res_o.wb.data = ea;
            end
            mseu_pkg::OP_BGE: begin
              if ($signed(rs_data_i) >= $signed(rt_data_i)) begin
                res_o.pc_next = seq + {imm_s[29:0], 2'b00};
              end
            end
            mseu_pkg::OP_J: begin
              res_o.pc_next = {seq[31:28], instruction_i[25:0], 2'b00};
            end
            mseu_pkg::OP_RTYPE: begin
              if (funct == mseu_pkg::FUNCT_ADD) begin
                wb_en         = 1'b1;
                res_o.wb.dest = rd_idx;
                res_o.wb.data = sum;
              end else begin
                res_o.status = mseu_pkg::ST_BAD_FUNCT;
              end
            end
            default: begin
              // illegal opcode: stop in place
              res_o.pc_next  = pc_i;
              res_o.status   = mseu_pkg::ST_ILLEGAL;
              res_o.set_halt = 1'b1;
            end
          endcase
        end
      end
      mseu_pkg::MODE_WRITE: begin
        res_o.mem.wr_en = 1'b1;
        res_o.mem.addr  = 32'(access_address_i);
        res_o.mem.wdata = access_data_i;
      end
      mseu_pkg::MODE_READ: begin
        res_o.mem.rd_en = 1'b1;
        res_o.mem.addr  = 32'(access_address_i);
      end
      default: begin
        // unused mode: no effect
      end
    endcase

    // register zero is never written
    res_o.wb.en = wb_en && (res_o.wb.dest != '0);
  end

endmodule

`default_nettype wire

/* hw/rtl/mips_subset_execute_unit.sv */
// Top level of the MIPS subset execute unit: pipeline, forwarding, output register.
`default_nettype none

// Takes one word per clock when the output side does not stall. The register file
// is read at the accepting edge, the execute stage issues the data memory access
// as the word moves to writeback, and writeback then loads the output register.
// The register file and the data memory are synchronous memories with registered
// read data; results still in flight are forwarded to the execute stage,
// including a load result to the very next word, so no word ever waits on an
// earlier one. PC and halt state update in the execute stage in word order.
// MEM_BYTES must be a power of two; byte addresses wrap at that size. The data
// memory holds no reset value and needs no clearing pass; registers read zero
// until written.
module mips_subset_execute_unit #(
  parameter int unsigned MEM_BYTES = 16384
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [1:0]                       mode_i,
  input  logic [31:0]                      instruction_i,
  input  logic [mseu_pkg::ACC_ADDR_W-1:0]  access_address_i,
  input  logic [31:0]                      access_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [31:0]                      next_pc_o,
  output logic [2:0]                       status_o,
  output logic [31:0]                      read_data_o
);

  // Handshake and stage moves
  logic accept;
  logic adv1;
  logic adv2;

  // Architectural state
  logic [31:0] pc_q;
  logic        halted_q;

  // Execute stage word
  logic                            s1_v_q;
  logic [1:0]                      s1_mode_q;
  logic [31:0]                     s1_ins_q;
  logic [mseu_pkg::ACC_ADDR_W-1:0] s1_acc_addr_q;
  logic [31:0]                     s1_acc_data_q;

  // Writeback stage word
  logic                 s2_v_q;
  mseu_pkg::reg_wb_t    s2_wb_q;
  logic [31:0]          s2_pc_q;
  logic [2:0]           s2_status_q;
  logic                 s2_dump_q;
  logic                 s2_byte_q;

  // Last register write, for words that read the file at the same edge
  logic                 wbh_v_q;
  logic [4:0]           wbh_dest_q;
  logic [31:0]          wbh_data_q;

  // Output register
  logic        out_v_q;
  logic [31:0] out_pc_q;
  logic [2:0]  out_status_q;
  logic [31:0] out_rdata_q;

  logic [31:0]         rs_rf;
  logic [31:0]         rt_rf;
  logic [31:0]         rs_fwd;
  logic [31:0]         rt_fwd;
  logic [4:0]          rs_idx;
  logic [4:0]          rt_idx;
  logic [31:0]         rd_word;
  logic [31:0]         ld_val;
  logic [31:0]         s2_wdata;
  logic                rf_we;
  mseu_pkg::exec_res_t res;

  // Flow control: each stage moves when the one ahead is free or moving
  assign adv2       = s2_v_q && (!out_v_q || !out_stall_i);
  assign adv1       = s1_v_q && (!s2_v_q || adv2);
  assign in_stall_o = s1_v_q && !adv1;
  assign accept     = in_valid_i && !in_stall_o;

  mseu_regfile u_regfile (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rs_addr_i (instruction_i[25:21]),
    .rt_addr_i (instruction_i[20:16]),
    .we_i      (rf_we),
    .waddr_i   (s2_wb_q.dest),
    .wdata_i   (s2_wdata),
    .rs_data_o (rs_rf),
    .rt_data_o (rt_rf)
  );

  // Load result, sign-extended for byte loads
  assign ld_val   = s2_byte_q ? {{24{rd_word[7]}}, rd_word[7:0]} : rd_word;
  assign s2_wdata = s2_wb_q.load ? ld_val : s2_wb_q.data;
  assign rf_we    = adv2 && s2_wb_q.en;

  // Operand forwarding: writeback stage first, then last write, then file
  assign rs_idx = s1_ins_q[25:21];
  assign rt_idx = s1_ins_q[20:16];

  always_comb begin
    if (s2_v_q && s2_wb_q.en && (s2_wb_q.dest == rs_idx)) begin
      rs_fwd = s2_wdata;
    end else if (wbh_v_q && (wbh_dest_q == rs_idx)) begin
      rs_fwd = wbh_data_q;
    end else begin
      rs_fwd = rs_rf;
    end
    if (s2_v_q && s2_wb_q.en && (s2_wb_q.dest == rt_idx)) begin
      rt_fwd = s2_wdata;
    end else if (wbh_v_q && (wbh_dest_q == rt_idx)) begin
      rt_fwd = wbh_data_q;
    end else begin
      rt_fwd = rt_rf;
    end
  end

  mseu_exec u_exec (
    .mode_i           (s1_mode_q),
    .instruction_i    (s1_ins_q),
    .access_address_i (s1_acc_addr_q),
    .access_data_i    (s1_acc_data_q),
    .pc_i             (pc_q),
    .halted_i         (halted_q),
    .rs_data_i        (rs_fwd),
    .rt_data_i        (rt_fwd),
    .res_o            (res)
  );

  mseu_dmem #(
    .MEM_BYTES (MEM_BYTES)
  ) u_dmem (
    .clk_i     (clk_i),
    .en_i      (adv1),
    .req_i     (res.mem),
    .rd_word_o (rd_word)
  );

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q     <= '0;
      halted_q <= 1'b0;
      s1_v_q   <= 1'b0;
      s2_v_q   <= 1'b0;
      wbh_v_q  <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (accept) begin
        s1_v_q <= 1'b1;
      end else if (adv1) begin
        s1_v_q <= 1'b0;
      end
      if (adv1) begin
        pc_q     <= res.pc_next;
        halted_q <= halted_q | res.set_halt;
        s2_v_q   <= 1'b1;
      end else if (adv2) begin
        s2_v_q <= 1'b0;
      end
      if (adv2) begin
        wbh_v_q <= s2_wb_q.en;
        out_v_q <= 1'b1;
      end else if (out_v_q && !out_stall_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_mode_q     <= mode_i;
      s1_ins_q      <= instruction_i;
      s1_acc_addr_q <= access_address_i;
      s1_acc_data_q <= access_data_i;
    end
    if (adv1) begin
      s2_wb_q     <= res.wb;
      s2_pc_q     <= res.pc_next;
      s2_status_q <= res.status;
      s2_dump_q   <= (s1_mode_q == mseu_pkg::MODE_READ);
      s2_byte_q   <= res.mem.byte_op;
    end
    if (adv2) begin
      wbh_dest_q   <= s2_wb_q.dest;
      wbh_data_q   <= s2_wdata;
      out_pc_q     <= s2_pc_q;
      out_status_q <= s2_status_q;
      out_rdata_q  <= s2_dump_q ? rd_word : '0;
    end
  end

  assign out_valid_o = out_v_q;
  assign next_pc_o   = out_pc_q;
  assign status_o    = out_status_q;
  assign read_data_o = out_rdata_q;

  // Register zero is never written
  a_no_r0_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rf_we |-> (s2_wb_q.dest != '0))
    else $error("write to register zero");

  // Input is held back only while the execute stage is occupied
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_v_q)
    else $error("input stalled with empty execute stage");

  // Once halted, the block stays halted
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> halted_q)
    else $error("halt flag cleared");

  // Read data only comes with a plain done status
  a_rdata_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (read_data_o != '0)) |-> (status_o == mseu_pkg::ST_DONE))
    else $error("read data on a non-dump result");

endmodule

`default_nettype wire

/* tb/sv/mips_subset_execute_unit_tb.sv */
// Self-checking testbench for the MIPS subset execute unit: shadow CPU predictor, driver, monitor.
`timescale 1ns / 1ps

module mips_subset_execute_unit_tb;

  localparam int unsigned MEM_BYTES    = 16384;
  localparam int unsigned RANDOM_WORDS = 1950;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam logic [1:0]  MODE_UNUSED  = 2'd3;
  // Two copies of the CPU state: one steers stimulus, one predicts the DUT
  localparam int          SHADOW_GEN   = 0;
  localparam int          SHADOW_DUT   = 1;

  typedef struct packed {
    logic [1:0]                      mode;
    logic [31:0]                     instruction;
    logic [mseu_pkg::ACC_ADDR_W-1:0] access_address;
    logic [31:0]                     access_data;
  } cpu_word_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic [2:0]  status;
    logic [31:0] read_data;
  } cpu_result_t;

  logic                            clk_i            = 1'b0;
  logic                            rst_ni           = 1'b0;
  logic                            in_valid_i       = 1'b0;
  logic                            in_stall_o;
  logic [1:0]                      mode_i           = mseu_pkg::MODE_EXEC;
  logic [31:0]                     instruction_i    = '0;
  logic [mseu_pkg::ACC_ADDR_W-1:0] access_address_i = '0;
  logic [31:0]                     access_data_i    = '0;
  logic                            out_valid_o;
  logic                            out_stall_i      = 1'b0;
  logic [31:0]                     next_pc_o;
  logic [2:0]                      status_o;
  logic [31:0]                     read_data_o;

  // Shadow architectural state
  bit [31:0] arch_pc     [2];
  bit [31:0] arch_regs   [2][mseu_pkg::REG_COUNT];
  bit [7:0]  arch_mem    [2][MEM_BYTES];
  bit        arch_halted [2];

  // Bytes written so far, so loads and dumps only touch defined memory
  bit          byte_seen [MEM_BYTES];
  logic [31:0] stored_at [$];

  cpu_word_t   words_to_send [$];
  cpu_result_t results_due [$];
  cpu_word_t   cur_word;
  int unsigned words_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches   = 0;
  int unsigned cycle_cnt    = 0;

  mips_subset_execute_unit #(
    .MEM_BYTES(MEM_BYTES)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .mode_i          (mode_i),
    .instruction_i   (instruction_i),
    .access_address_i(access_address_i),
    .access_data_i   (access_data_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .next_pc_o       (next_pc_o),
    .status_o        (status_o),
    .read_data_o     (read_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Little-endian word access with byte-wise address wrap
  function automatic logic [31:0] get_word(int s, logic [31:0] addr);
    logic [31:0] w;
    w = '0;
    for (int i = 0; i < 4; i++) w[8*i +: 8] = arch_mem[s][(addr + i) % MEM_BYTES];
    return w;
  endfunction

  function automatic void put_word(int s, logic [31:0] addr, logic [31:0] w);
    for (int i = 0; i < 4; i++) arch_mem[s][(addr + i) % MEM_BYTES] = w[8*i +: 8];
  endfunction

  // r0 always reads zero
  function automatic void set_reg(int s, logic [4:0] idx, logic [31:0] v);
    if (idx != 5'd0) arch_regs[s][idx] = v;
  endfunction

  // One word through the shadow CPU: updates state, returns the result
  function automatic cpu_result_t step_cpu(int s, cpu_word_t w);
    cpu_result_t r;
    logic [31:0] ins, rs_v, rt_v, imm, seq;
    logic [7:0]  b;
    ins  = w.instruction;
    rs_v = arch_regs[s][ins[25:21]];
    rt_v = arch_regs[s][ins[20:16]];
    imm  = {{16{ins[15]}}, ins[15:0]};
    seq  = arch_pc[s] + 32'd4;
    r    = '0;
    if (w.mode == mseu_pkg::MODE_WRITE) begin
      put_word(s, 32'(w.access_address), w.access_data);
    end else if (w.mode == mseu_pkg::MODE_READ) begin
      r.read_data = get_word(s, 32'(w.access_address));
    end else if (w.mode == mseu_pkg::MODE_EXEC && arch_halted[s]) begin
      r.status = mseu_pkg::ST_HALTED;
    end else if (w.mode == mseu_pkg::MODE_EXEC && ins == '0) begin
      arch_halted[s] = 1'b1;
      r.status       = mseu_pkg::ST_END;
    end else if (w.mode == mseu_pkg::MODE_EXEC) begin
      r.status = mseu_pkg::ST_DONE;
      case (ins[31:26])
        mseu_pkg::OP_LA:   set_reg(s, ins[20:16], {16'h0000, ins[15:0]});
        mseu_pkg::OP_LB: begin
          b = arch_mem[s][(rs_v + imm) % MEM_BYTES];
          set_reg(s, ins[20:16], {{24{b[7]}}, b});
        end
        mseu_pkg::OP_LW:   set_reg(s, ins[20:16], get_word(s, rs_v + imm));
        mseu_pkg::OP_SW:   put_word(s, rs_v + imm, rt_v);
        mseu_pkg::OP_ADDI: set_reg(s, ins[20:16], rs_v + imm);
        mseu_pkg::OP_BGE: begin
          if ($signed(rs_v) >= $signed(rt_v)) seq = seq + (imm << 2);
        end
        mseu_pkg::OP_J:    seq = {seq[31:28], ins[25:0], 2'b00};
        mseu_pkg::OP_RTYPE: begin
          if (ins[5:0] == mseu_pkg::FUNCT_ADD) set_reg(s, ins[15:11], rs_v + rt_v);
          else r.status = mseu_pkg::ST_BAD_FUNCT;
        end
        default: begin
          arch_halted[s] = 1'b1;
          r.status       = mseu_pkg::ST_ILLEGAL;
        end
      endcase
      if (!arch_halted[s]) arch_pc[s] = seq;
    end
    r.next_pc = arch_pc[s];
    return r;
  endfunction

  // Stimulus bookkeeping
  function automatic void note_store(logic [31:0] addr);
    for (int i = 0; i < 4; i++) byte_seen[(addr + i) % MEM_BYTES] = 1'b1;
    stored_at.push_back(addr % MEM_BYTES);
  endfunction

  function automatic void queue_word(cpu_word_t w);
    logic [31:0] ins;
    ins = w.instruction;
    if (w.mode == mseu_pkg::MODE_WRITE) note_store(32'(w.access_address));
    if (w.mode == mseu_pkg::MODE_EXEC && !arch_halted[SHADOW_GEN] &&
        ins[31:26] == mseu_pkg::OP_SW)
      note_store(arch_regs[SHADOW_GEN][ins[25:21]] + {{16{ins[15]}}, ins[15:0]});
    void'(step_cpu(SHADOW_GEN, w));
    words_to_send.push_back(w);
  endfunction

  // Address whose next span bytes were all written
  function automatic logic [31:0] readable_addr(int unsigned span);
    logic [31:0] a;
    bit          ok;
    a  = $urandom_range(0, MEM_BYTES - 1);
    ok = 1'b1;
    for (int i = 0; i < span; i++) if (!byte_seen[(a + i) % MEM_BYTES]) ok = 1'b0;
    if (!ok) a = stored_at[$urandom_range(0, stored_at.size() - 1)] + $urandom_range(0, 4 - span);
    return a % MEM_BYTES;
  endfunction

  // Offset that makes base register + offset land on target after wrap
  function automatic logic [15:0] reach_imm(logic [4:0] base, logic [31:0] target);
    logic [31:0] d;
    d = (target - arch_regs[SHADOW_GEN][base]) % MEM_BYTES;
    return 16'(d + MEM_BYTES * $urandom_range(0, 3));
  endfunction

  function automatic cpu_word_t i_word(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                       logic [15:0] imm);
    cpu_word_t w;
    w.mode           = mseu_pkg::MODE_EXEC;
    w.instruction    = {op, rs, rt, imm};
    w.access_address = mseu_pkg::ACC_ADDR_W'($urandom());
    w.access_data    = $urandom();
    return w;
  endfunction

  function automatic cpu_word_t r_word(logic [4:0] rs, logic [4:0] rt, logic [4:0] rd,
                                       logic [5:0] funct);
    return i_word(mseu_pkg::OP_RTYPE, rs, rt, {rd, 5'($urandom()), funct});
  endfunction

  function automatic cpu_word_t io_word(logic [1:0] mode,
                                        logic [mseu_pkg::ACC_ADDR_W-1:0] addr,
                                        logic [31:0] data);
    cpu_word_t w;
    w.mode           = mode;
    w.instruction    = $urandom();
    w.access_address = addr;
    w.access_data    = data;
    return w;
  endfunction

  // Random idling, with a quiet stretch in the middle of the run
  function automatic bit idle_roll(int unsigned n);
    return !(n >= 700 && n < 1000) && ($urandom_range(0, 99) < 21);
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  task automatic wait_drained();
    do @(negedge clk_i);
    while (words_to_send.size() != 0 || in_valid_i || results_due.size() != 0);
  endtask

  // Driver: hold the word while stalled, otherwise maybe present the next one
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        results_due.push_back(step_cpu(SHADOW_DUT, cur_word));
        words_sent++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (words_to_send.size() != 0 && !idle_roll(words_sent)) begin
          cur_word          = words_to_send.pop_front();
          in_valid_i       <= 1'b1;
          mode_i           <= cur_word.mode;
          instruction_i    <= cur_word.instruction;
          access_address_i <= cur_word.access_address;
          access_data_i    <= cur_word.access_data;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted result with the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    cpu_result_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (results_due.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, actual pc %h status %0d data %h",
                   $time, next_pc_o, status_o, read_data_o);
          mismatches++;
        end else begin
          want = results_due.pop_front();
          check_field("next_pc", want.next_pc, next_pc_o);
          check_field("status", 32'(want.status), 32'(status_o));
          check_field("read_data", want.read_data, read_data_o);
        end
      end
      out_stall_i <= idle_roll(results_seen);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("%0t ns: timeout, %0d results still due", $time, results_due.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    cpu_word_t   w;
    int unsigned pick;
    bit          end_first;
    rst_ni = 1'b0;

    // Directed: wrap, signed extremes, sign extension, r0, bad funct, max jump
    queue_word(io_word(mseu_pkg::MODE_WRITE, 14'h3FFF, 32'h00C0FFEE));
    queue_word(io_word(mseu_pkg::MODE_WRITE, 14'h0000, 32'h80000000));
    queue_word(io_word(mseu_pkg::MODE_READ, 14'h3FFF, 32'h0));
    queue_word(io_word(mseu_pkg::MODE_WRITE, 14'h0004, 32'h7FFFFFFF));
    queue_word(i_word(mseu_pkg::OP_LW, 5'd0, 5'd2, 16'h0000));
    queue_word(i_word(mseu_pkg::OP_LW, 5'd0, 5'd3, 16'h0004));
    queue_word(i_word(mseu_pkg::OP_BGE, 5'd3, 5'd2, 16'h0003));
    queue_word(i_word(mseu_pkg::OP_BGE, 5'd2, 5'd3, 16'hFFFF));
    queue_word(i_word(mseu_pkg::OP_BGE, 5'd2, 5'd2, 16'h8000));
    queue_word(r_word(5'd2, 5'd3, 5'd4, mseu_pkg::FUNCT_ADD));
    queue_word(r_word(5'd4, 5'd4, 5'd5, mseu_pkg::FUNCT_ADD));
    queue_word(i_word(mseu_pkg::OP_ADDI, 5'd0, 5'd6, 16'hFFFF));
    queue_word(i_word(mseu_pkg::OP_ADDI, 5'd6, 5'd7, 16'h7FFF));
    queue_word(i_word(mseu_pkg::OP_LB, 5'd0, 5'd8, 16'h0003));
    queue_word(i_word(mseu_pkg::OP_LB, 5'd0, 5'd9, 16'h0000));
    queue_word(i_word(mseu_pkg::OP_LA, 5'd0, 5'd10, 16'hFFFF));
    queue_word(i_word(mseu_pkg::OP_LA, 5'd31, 5'd0, 16'h1234));
    queue_word(r_word(5'd0, 5'd10, 5'd11, mseu_pkg::FUNCT_ADD));
    queue_word(i_word(mseu_pkg::OP_ADDI, 5'd0, 5'd12, 16'h3FFE));
    queue_word(i_word(mseu_pkg::OP_SW, 5'd12, 5'd4, 16'h0001));
    queue_word(i_word(mseu_pkg::OP_LW, 5'd12, 5'd13, 16'h0001));
    queue_word(i_word(mseu_pkg::OP_RTYPE, 5'h1F, 5'h1F, 16'hFFFF));
    queue_word(i_word(mseu_pkg::OP_J, 5'h1F, 5'h1F, 16'hFFFF));
    queue_word(io_word(MODE_UNUSED, 14'h3FFF, 32'hFFFFFFFF));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Sender holds off until the directed part has fully drained
    wait_drained();

    // Random part: mostly well-formed instructions, some memory traffic
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      pick = $urandom_range(0, 99);
      w    = io_word(mseu_pkg::MODE_EXEC, 14'($urandom()), $urandom());
      if (pick < 10) begin
        w.mode = mseu_pkg::MODE_WRITE;
      end else if (pick < 17) begin
        w.mode           = mseu_pkg::MODE_READ;
        w.access_address = 14'(readable_addr(4));
      end else if (pick < 19) begin
        w.mode = MODE_UNUSED;
      end else begin
        case ($urandom_range(0, 8))
          0: w.instruction[31:26] = mseu_pkg::OP_LA;
          1: begin
            w.instruction[31:26] = mseu_pkg::OP_LB;
            w.instruction[15:0]  = reach_imm(w.instruction[25:21], readable_addr(1));
          end
          2: begin
            w.instruction[31:26] = mseu_pkg::OP_LW;
            w.instruction[15:0]  = reach_imm(w.instruction[25:21], readable_addr(4));
          end
          3: w.instruction[31:26] = mseu_pkg::OP_SW;
          4: w.instruction[31:26] = mseu_pkg::OP_ADDI;
          5: w.instruction[31:26] = mseu_pkg::OP_BGE;
          6: w.instruction[31:26] = mseu_pkg::OP_J;
          7: begin
            w.instruction[31:26] = mseu_pkg::OP_RTYPE;
            w.instruction[5:0]   = mseu_pkg::FUNCT_ADD;
          end
          default: begin
            w.instruction[31:26] = mseu_pkg::OP_RTYPE;
            if (w.instruction[5:0] == mseu_pkg::FUNCT_ADD) w.instruction[0] = 1'b1;
            if (w.instruction == '0) w.instruction[0] = 1'b1;
          end
        endcase
      end
      queue_word(w);
    end
    wait_drained();

    // Halting tail: end word and illegal opcode in random order, then halted traffic
    end_first = 1'($urandom_range(0, 1));
    w         = io_word(mseu_pkg::MODE_EXEC, 14'($urandom()), $urandom());
    w.instruction = '0;
    if (end_first) queue_word(w);
    w.instruction         = $urandom();
    w.instruction[31:26]  = 6'($urandom_range(16, 31)) | {1'($urandom_range(0, 1)), 5'd0};
    queue_word(w);
    if (!end_first) begin
      w.instruction = '0;
      queue_word(w);
    end
    queue_word(i_word(mseu_pkg::OP_ADDI, 5'($urandom()), 5'($urandom()), 16'($urandom())));
    queue_word(i_word(mseu_pkg::OP_J, 5'($urandom()), 5'($urandom()), 16'($urandom())));
    queue_word(io_word(mseu_pkg::MODE_WRITE, 14'h2A55, $urandom()));
    queue_word(io_word(mseu_pkg::MODE_READ, 14'h2A55, $urandom()));
    queue_word(io_word(MODE_UNUSED, 14'($urandom()), $urandom()));
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (results_due.size() != 0) begin
      $display("%0t ns: %0d expected results never arrived", $time, results_due.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* mips_subset_execute_unit.f */
hw/rtl/mseu_pkg.sv
hw/rtl/mseu_regfile.sv
hw/rtl/mseu_dmem.sv
hw/rtl/mseu_exec.sv
hw/rtl/mips_subset_execute_unit.sv
tb/sv/mips_subset_execute_unit_tb.sv
